/* rtl/core/pfmvs_pkg.sv */
// ----------------------------------------------------------------------------
// pfmvs_pkg
// Shared widths, codes and types of the polyphonic FM voice synthesiser.
// ----------------------------------------------------------------------------
package pfmvs_pkg;

  localparam int unsigned MODE_W     = 2;
  localparam int unsigned NOTE_W     = 7;
  localparam int unsigned VEL_W      = 7;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned TIME_W     = 24;
  localparam int unsigned LEVEL_W    = 17;
  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned RATIO_W    = 16;
  localparam int unsigned GAIN_W     = 12;
  localparam int unsigned SIN_W      = 15;
  localparam int unsigned BASE_W     = 34;
  localparam int unsigned PROD_W     = 41;
  localparam int unsigned QUO_W      = 17;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE = 17'd65536;
  localparam logic [TIME_W-1:0]  TIME_MAX  = 24'hFFFFFF;

  typedef enum logic [MODE_W-1:0] {
    MODE_NOTE_ON  = 2'd0,
    MODE_NOTE_OFF = 2'd1,
    MODE_TICK     = 2'd2,
    MODE_NONE     = 2'd3
  } mode_e;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_PROD, S_DIV, S_GAIN, S_VEL, S_AMP, S_DEV, S_WB, S_OUT
  } state_e;

  localparam logic [16:0] SEMITONE_Q16 [12] = '{
    17'd65536, 17'd69433, 17'd73562, 17'd77936, 17'd82570, 17'd87480,
    17'd92682, 17'd98193, 17'd104032, 17'd110218, 17'd116772, 17'd123715
  };

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [TIME_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/core/pfmvs_if.sv */
// ----------------------------------------------------------------------------
// pfmvs_if
// Valid/ready channels of the synthesiser: event input, sample output and
// register write port.
// ----------------------------------------------------------------------------
interface pfmvs_in_if;
  import pfmvs_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [NOTE_W-1:0] note_number;
  logic [VEL_W-1:0]  key_velocity;
  modport source (output valid, mode, note_number, key_velocity, input ready);
  modport sink (input valid, mode, note_number, key_velocity, output ready);
endinterface

interface pfmvs_out_if;
  import pfmvs_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] audio_sample;
  modport source (output valid, audio_sample, input ready);
  modport sink (input valid, audio_sample, output ready);
endinterface

interface pfmvs_cfg_if;
  import pfmvs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/pfmvs_div.sv */
// ----------------------------------------------------------------------------
// pfmvs_div
// Bit-serial restoring divider: one quotient bit per cycle, 17-bit quotient.
// ----------------------------------------------------------------------------
module pfmvs_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pfmvs_pkg::div_req_t req_i,
  output pfmvs_pkg::div_rsp_t rsp_o
);
  import pfmvs_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUO_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TIME_W-1:0] rem_q, rem_d;
  logic [TIME_W-1:0] dsr_q, dsr_d;
  logic [QUO_W-1:0]  dq_q, dq_d;
  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   diff;
  logic              fits;

  assign trial = {rem_q, dq_q[QUO_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    dq_d   = dq_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = req_i.dividend[PROD_W-1:QUO_W];
      dq_d   = req_i.dividend[QUO_W-1:0];
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      dq_d  = {dq_q[QUO_W-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(QUO_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    dq_q  <= dq_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dq_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without a run");
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q || $past(req_i.start)) else $error("divider still busy at done");
  a_start_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q && cnt_q == '0) else $error("divider start not taken");

endmodule

/* rtl/core/polyphonic_fm_voice_synth_core.sv */
// ----------------------------------------------------------------------------
// polyphonic_fm_voice_synth_core
// Polyphonic two-operator FM synthesiser with a linear ADSR per voice.
// ----------------------------------------------------------------------------
// Channels: in_i takes events (note on, note off, sample tick), out_o gives
// one signed sample per tick, cfg_i writes the envelope, FM and gain
// registers (always ready; write only while the core is idle).
// Note on and note off are handled in the idle state. A tick walks the voices
// one after the other on a single datapath. An active voice whose envelope
// needs a division (attack, decay, release) runs the bit-serial divider twice
// (envelope and velocity scaling), and each quotient is handed over; a voice
// in sustain or past its release runs it once, and an idle voice goes no
// further than the fetch. The steps are fetch, product, divide, gain, velocity,
// amplitude, divide, deviation and write-back, then the sample is registered.
// Events are taken one at a time; the core accepts the next event once the
// sample has been placed in the output register.
// When the receiver stalls, the sample waits in the output register; a later
// tick holds at its end until that register is free.
// Reset clears all voices, phases and envelope times and loads the default
// register values.
// ----------------------------------------------------------------------------
module polyphonic_fm_voice_synth_core #(
  parameter int unsigned VOICES       = 8,
  parameter int unsigned SAMPLE_RATE  = 44100,
  parameter int unsigned SINE_ENTRIES = 1024
) (
  input logic        clk_i,
  input logic        rst_ni,
  pfmvs_in_if.sink   in_i,
  pfmvs_out_if.source out_o,
  pfmvs_cfg_if.sink  cfg_i
);
  import pfmvs_pkg::*;

  localparam int unsigned VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned LG    = $clog2(SINE_ENTRIES);
  localparam int unsigned QTR   = SINE_ENTRIES / 4;
  localparam int unsigned JW    = LG - 1;
  localparam int unsigned MIX_W = 14 + $clog2(VOICES);

  localparam longint unsigned NOTE_DEN  = 64'd1000 * SAMPLE_RATE;
  localparam longint unsigned NOTE_HALF = 64'd500 * SAMPLE_RATE;

  typedef logic [SIN_W-1:0]  sine_tbl_t [QTR+1];
  typedef logic [BASE_W-1:0] note_tbl_t [128];

  function automatic sine_tbl_t build_sine();
    sine_tbl_t         tbl;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            acc;
    for (int j = 0; j <= QTR; j++) begin
      x    = (longint'(j) * 64'd1686629713) >> (LG - 2);
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int k = 1; k <= 5; k++) begin
        term = (term * x2) >> 30;
        case (k)
          1:       term = term / 6;
          2:       term = term / 20;
          3:       term = term / 42;
          4:       term = term / 72;
          default: term = term / 110;
        endcase
        if ((k % 2) == 1) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      acc = (acc + 16384) >>> 15;
      if (acc > 32767) acc = 32767;
      tbl[j] = SIN_W'(acc);
    end
    return tbl;
  endfunction

  function automatic note_tbl_t build_notes();
    note_tbl_t       tbl;
    longint unsigned num;
    for (int n = 0; n < 128; n++) begin
      num    = (64'd8176 * SEMITONE_Q16[n % 12]) << (n / 12 + 16);
      tbl[n] = BASE_W'((num + NOTE_HALF) / NOTE_DEN);
    end
    return tbl;
  endfunction

  localparam sine_tbl_t SINE_TBL = build_sine();
  localparam note_tbl_t NOTE_TBL = build_notes();

  // registers
  logic [TIME_W-1:0]  attack_q, decay_q, release_q;
  logic [LEVEL_W-1:0] sustain_q;
  logic [RATIO_W-1:0] ratio_q;
  logic [PHASE_W-1:0] depth_q;
  logic [GAIN_W-1:0]  gain_q;

  // voice state
  logic [VOICES-1:0]  active_q, gate_q;
  logic [NOTE_W-1:0]  note_q   [VOICES];
  logic [VEL_W-1:0]   vel_q    [VOICES];
  logic [TIME_W-1:0]  time_q   [VOICES];
  logic [LEVEL_W-1:0] level_q  [VOICES];
  logic [PHASE_W-1:0] cphase_q [VOICES];
  logic [PHASE_W-1:0] mphase_q [VOICES];

  // sequencer and datapath
  state_e                  state_q, state_d;
  logic [VW-1:0]           vidx_q;
  logic [LEVEL_W-1:0]      env_q, mul_a_q;
  logic [TIME_W-1:0]       mul_b_q, dsr_q;
  logic                    sub_q, freed_q, div_mix_q, fetch_q;
  logic [28:0]             eg_q;
  logic [35:0]             egv_q;
  logic signed [MIX_W-1:0] mix_q;
  logic [PHASE_W-1:0]      dmag_q, minc_q;
  logic                    ms_neg_q;
  logic [SIN_W-1:0]        sin_mag_q, cs_mag_q;
  logic                    sin_neg_q, cs_neg_q;
  logic                    out_valid_q;
  logic [SAMPLE_W-1:0]     out_sample_q;

  // combinational
  logic                in_acc, out_acc, cfg_acc;
  logic                free_found;
  logic [VW-1:0]       free_idx;
  logic [TIME_W-1:0]   a_eff, d_eff, r_eff, t_cur;
  logic [LEVEL_W-1:0]  s_eff;
  logic [TIME_W:0]     ad_sum;
  logic                gated, active, over_ad, over_a, over_r, last_voice;
  logic [PHASE_W-1:0]  sin_phase;
  logic [LG-1:0]       sin_i;
  logic [JW-1:0]       sin_j;
  logic [BASE_W-1:0]   base;
  logic [50:0]         amp_prod;
  logic [46:0]         dev_prod;
  logic [49:0]         minc_prod;
  logic [PHASE_W-1:0]  dev_signed;
  logic signed [31:0]  mix_ext;
  logic [SAMPLE_W-1:0] sat_sample;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;
  assign cfg_acc = cfg_i.valid && cfg_i.ready;

  assign in_i.ready         = (state_q == S_IDLE);
  assign cfg_i.ready        = 1'b1;
  assign out_o.valid        = out_valid_q;
  assign out_o.audio_sample = out_sample_q;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int v = VOICES - 1; v >= 0; v--) begin
      if (!active_q[v]) begin
        free_found = 1'b1;
        free_idx   = VW'(v);
      end
    end
  end

  assign a_eff   = (attack_q == '0) ? TIME_W'(1) : attack_q;
  assign d_eff   = (decay_q == '0) ? TIME_W'(1) : decay_q;
  assign r_eff   = (release_q == '0) ? TIME_W'(1) : release_q;
  assign s_eff   = (sustain_q > LEVEL_ONE) ? LEVEL_ONE : sustain_q;
  assign ad_sum  = {1'b0, a_eff} + {1'b0, d_eff};
  assign t_cur   = time_q[vidx_q];
  assign gated   = gate_q[vidx_q];
  assign active  = active_q[vidx_q];
  assign over_ad = {1'b0, t_cur} > ad_sum;
  assign over_a  = t_cur > a_eff;
  assign over_r  = t_cur > r_eff;
  assign last_voice = (vidx_q == VW'(VOICES - 1));

  // quarter-wave sine lookup, registered
  assign sin_phase = (state_q == S_FETCH) ? cphase_q[vidx_q] : mphase_q[vidx_q];
  assign sin_i     = sin_phase[PHASE_W-1 -: LG];
  assign sin_j     = sin_i[LG-2] ? (JW'(QTR) - {1'b0, sin_i[LG-3:0]})
                                 : {1'b0, sin_i[LG-3:0]};

  assign base       = NOTE_TBL[note_q[vidx_q]];
  assign amp_prod   = egv_q * cs_mag_q;
  assign dev_prod   = depth_q * sin_mag_q;
  assign minc_prod  = base * ratio_q;
  assign dev_signed = ms_neg_q ? (PHASE_W'(0) - dmag_q) : dmag_q;

  assign mix_ext    = 32'(mix_q);
  assign sat_sample = (mix_ext > 32'sd32767)  ? 16'h7FFF :
                      (mix_ext < -32'sd32768) ? 16'h8000 : mix_ext[SAMPLE_W-1:0];

  always_comb begin
    div_req.start    = (state_q == S_PROD) || (state_q == S_AMP);
    div_req.dividend = (state_q == S_AMP) ? PROD_W'(amp_prod[50:31]) : mul_a_q * mul_b_q;
    div_req.divisor  = (state_q == S_AMP) ? TIME_W'(127) : dsr_q;
  end

  pfmvs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_i.mode == MODE_TICK) state_d = S_FETCH;
      end
      S_FETCH: begin
        if (!active) state_d = last_voice ? S_OUT : S_FETCH;
        else if (gated ? over_ad : over_r) state_d = S_GAIN;
        else state_d = S_PROD;
      end
      S_PROD: state_d = S_DIV;
      S_DIV: begin
        if (div_rsp.done) state_d = div_mix_q ? S_DEV : S_GAIN;
      end
      S_GAIN: state_d = S_VEL;
      S_VEL:  state_d = S_AMP;
      S_AMP:  state_d = S_DIV;
      S_DEV:  state_d = S_WB;
      S_WB:   state_d = last_voice ? S_OUT : S_FETCH;
      S_OUT: begin
        if (!out_valid_q || out_o.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      attack_q    <= 24'd441;
      decay_q     <= 24'd35280;
      sustain_q   <= 17'd6554;
      release_q   <= 24'd8820;
      ratio_q     <= 16'd30720;
      depth_q     <= 32'd9739155;
      gain_q      <= 12'd500;
      active_q    <= '0;
      gate_q      <= '0;
      for (int v = 0; v < VOICES; v++) begin
        time_q[v]   <= '0;
        level_q[v]  <= '0;
        cphase_q[v] <= '0;
        mphase_q[v] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_acc) begin
        case (cfg_i.index)
          CFG_ATTACK:  attack_q  <= cfg_i.data[TIME_W-1:0];
          CFG_DECAY:   decay_q   <= cfg_i.data[TIME_W-1:0];
          CFG_SUSTAIN: sustain_q <= cfg_i.data[LEVEL_W-1:0];
          CFG_RELEASE: release_q <= cfg_i.data[TIME_W-1:0];
          CFG_RATIO:   ratio_q   <= cfg_i.data[RATIO_W-1:0];
          CFG_DEPTH:   depth_q   <= cfg_i.data;
          CFG_GAIN:    gain_q    <= cfg_i.data[GAIN_W-1:0];
          default: ;
        endcase
      end

      if (in_acc && in_i.mode == MODE_NOTE_ON && free_found) begin
        active_q[free_idx] <= 1'b1;
        gate_q[free_idx]   <= 1'b1;
        time_q[free_idx]   <= '0;
      end
      if (in_acc && in_i.mode == MODE_NOTE_OFF) begin
        for (int v = 0; v < VOICES; v++) begin
          if (active_q[v] && gate_q[v] && note_q[v] == in_i.note_number) begin
            gate_q[v] <= 1'b0;
            time_q[v] <= '0;
          end
        end
      end

      if (state_q == S_WB) begin
        if (t_cur != TIME_MAX) time_q[vidx_q] <= t_cur + TIME_W'(1);
        cphase_q[vidx_q] <= cphase_q[vidx_q] + base[PHASE_W-1:0] + dev_signed;
        mphase_q[vidx_q] <= mphase_q[vidx_q] + minc_q;
        if (gated) level_q[vidx_q] <= env_q;
        else if (freed_q) level_q[vidx_q] <= '0;
        if (freed_q) active_q[vidx_q] <= 1'b0;
      end

      if (state_q == S_OUT && (!out_valid_q || out_o.ready)) out_valid_q <= 1'b1;
      else if (out_acc) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    sin_mag_q <= SINE_TBL[sin_j];
    sin_neg_q <= sin_i[LG-1];
    fetch_q   <= (state_q == S_FETCH);
    if (fetch_q) begin
      cs_mag_q <= sin_mag_q;
      cs_neg_q <= sin_neg_q;
    end

    if (in_acc && in_i.mode == MODE_NOTE_ON && free_found) begin
      note_q[free_idx] <= in_i.note_number;
      vel_q[free_idx]  <= in_i.key_velocity;
    end

    if (in_acc && in_i.mode == MODE_TICK) begin
      vidx_q <= '0;
      mix_q  <= '0;
    end

    case (state_q)
      S_FETCH: begin
        freed_q <= !gated && over_r;
        if (gated) begin
          if (over_ad) begin
            env_q <= s_eff;
          end else if (over_a) begin
            mul_a_q <= LEVEL_ONE - s_eff;
            mul_b_q <= t_cur - a_eff;
            dsr_q   <= d_eff;
            sub_q   <= 1'b1;
          end else begin
            mul_a_q <= LEVEL_ONE;
            mul_b_q <= t_cur;
            dsr_q   <= a_eff;
            sub_q   <= 1'b0;
          end
        end else if (over_r) begin
          env_q <= '0;
        end else begin
          mul_a_q <= level_q[vidx_q];
          mul_b_q <= r_eff - t_cur;
          dsr_q   <= r_eff;
          sub_q   <= 1'b0;
        end
        if (!active && !last_voice) vidx_q <= vidx_q + VW'(1);
      end
      S_PROD: div_mix_q <= 1'b0;
      S_AMP:  div_mix_q <= 1'b1;
      S_DIV: begin
        if (div_rsp.done) begin
          if (!div_mix_q) begin
            env_q <= sub_q ? (LEVEL_ONE - div_rsp.quotient) : div_rsp.quotient;
          end else if (cs_neg_q) begin
            mix_q <= mix_q - $signed({{(MIX_W-13){1'b0}}, div_rsp.quotient[12:0]});
          end else begin
            mix_q <= mix_q + $signed({{(MIX_W-13){1'b0}}, div_rsp.quotient[12:0]});
          end
        end
      end
      S_GAIN: eg_q  <= env_q * gain_q;
      S_VEL:  egv_q <= eg_q * vel_q[vidx_q];
      S_DEV: begin
        dmag_q   <= dev_prod[46:15];
        minc_q   <= minc_prod[43:12];
        ms_neg_q <= sin_neg_q;
      end
      S_WB: begin
        if (!last_voice) vidx_q <= vidx_q + VW'(1);
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) out_sample_q <= sat_sample;
      end
      default: ;
    endcase
  end

  a_gate_needs_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gate_q & ~active_q) == '0) else $error("gated voice is not active");
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV) else $error("divider result outside wait");
  a_tick_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.mode == MODE_TICK |=> !in_i.ready) else $error("tick not taken");
  a_sample_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT) else $error("sample out of sequence");
  a_vidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FETCH |-> vidx_q <= VW'(VOICES - 1)) else $error("voice index out of range");

endmodule

/* tb/sv/tb_pfmvs_if.sv */
// ----------------------------------------------------------------------------
// tb_pfmvs_if
// Channels used by the testbench: the bench binds the event, sample and
// register write interfaces of the core itself, so none are declared here.
// ----------------------------------------------------------------------------

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the polyphonic FM voice synthesiser.
// Every accepted event updates a voice predictor held in the bench; each
// tick queues the expected mixed sample, and the samples that come out are
// compared in order. Directed cases cover voice allocation limits, note-off,
// envelope phases, register extremes and the unused mode; random phases run
// note sequences under random gaps, a long output stall and a drain pause.
// ----------------------------------------------------------------------------
module tb;
  import pfmvs_pkg::*;

  localparam int unsigned NV        = 8;
  localparam int unsigned RATE      = 44100;
  localparam int unsigned NSINE     = 1024;
  localparam int unsigned IDLE_WAIT = 46 * NV + 20;
  localparam int unsigned WD_LIMIT  = 200000;

  logic clk_i;
  logic rst_ni;

  pfmvs_in_if  in_ch ();
  pfmvs_out_if out_ch ();
  pfmvs_cfg_if cfg_ch ();

  polyphonic_fm_voice_synth_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source),
    .cfg_i  (cfg_ch.sink)
  );

  // predictor state
  logic [23:0] p_attack, p_decay, p_release;
  logic [16:0] p_sustain;
  logic [15:0] p_ratio;
  logic [31:0] p_depth;
  logic [11:0] p_gain;
  bit          v_active [NV];
  bit          v_gate [NV];
  logic [6:0]  v_note [NV];
  logic [6:0]  v_vel [NV];
  logic [23:0] v_time [NV];
  logic [16:0] v_level [NV];
  logic [31:0] v_carrier [NV];
  logic [31:0] v_mod [NV];

  logic signed [15:0] sample_queue [$];
  int unsigned errors;
  int unsigned ticks_sent;
  int unsigned events_sent;
  int unsigned samples_seen;
  int unsigned idle_cycles;
  int unsigned hold_off;
  bit          rand_stall;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int sine_lookup(logic [31:0] phase);
    longint unsigned idx, q, r, x, x2, term;
    longint acc;
    idx = (64'(phase) * NSINE) >> 32;
    q = (idx * 4) / NSINE;
    r = idx * 4 - q * NSINE;
    if (q[0]) begin
      r = NSINE - r;
    end
    x = (r * 64'd1686629713) / NSINE;
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (int k = 1; k <= 5; k++) begin
      term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc -= longint'(term);
      end else begin
        acc += longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + 16384) / 32768;
    if (acc > 32767) begin
      acc = 32767;
    end
    return (q >= 2) ? -int'(acc) : int'(acc);
  endfunction

  function automatic longint unsigned note_step(logic [6:0] n);
    longint unsigned num, den;
    num = (64'd8176 * SEMITONE_Q16[n % 12]) << (n / 12 + 16);
    den = 64'd1000 * RATE;
    return (num + den / 2) / den;
  endfunction

  function automatic logic signed [15:0] mix_tick();
    longint unsigned a, d, r, s, t, env, mag, base, dmag;
    longint mix;
    int cs, ms;
    bit freed;
    a = (p_attack == 0) ? 1 : p_attack;
    d = (p_decay == 0) ? 1 : p_decay;
    r = (p_release == 0) ? 1 : p_release;
    s = (p_sustain > 17'd65536) ? 65536 : p_sustain;
    mix = 0;
    for (int v = 0; v < NV; v++) begin
      if (!v_active[v]) begin
        continue;
      end
      freed = 1'b0;
      t = v_time[v];
      if (v_gate[v]) begin
        if (t > a + d) begin
          env = s;
        end else if (t > a) begin
          env = 65536 - ((65536 - s) * (t - a)) / d;
        end else begin
          env = (t * 65536) / a;
        end
        v_level[v] = env[16:0];
      end else if (t > r) begin
        env = 0;
        v_level[v] = '0;
        freed = 1'b1;
      end else begin
        env = (64'(v_level[v]) * (r - t)) / r;
      end
      cs = sine_lookup(v_carrier[v]);
      mag = env * p_gain * v_vel[v] * longint'(cs < 0 ? -cs : cs);
      mag /= 64'd127 * 65536 * 32768;
      mix += (cs < 0) ? -longint'(mag) : longint'(mag);
      if (v_time[v] != TIME_MAX) begin
        v_time[v]++;
      end
      base = note_step(v_note[v]);
      ms = sine_lookup(v_mod[v]);
      dmag = (64'(p_depth) * longint'(ms < 0 ? -ms : ms)) >> 15;
      if (ms < 0) begin
        v_carrier[v] = 32'(v_carrier[v] + base - dmag);
      end else begin
        v_carrier[v] = 32'(v_carrier[v] + base + dmag);
      end
      v_mod[v] = 32'(v_mod[v] + ((base * p_ratio) >> 12));
      if (freed) begin
        v_active[v] = 1'b0;
      end
    end
    if (mix > 32767) begin
      mix = 32767;
    end
    if (mix < -32768) begin
      mix = -32768;
    end
    return 16'(mix);
  endfunction

  function automatic void predict_event(mode_e m, logic [6:0] n, logic [6:0] vel);
    case (m)
      MODE_NOTE_ON: begin
        for (int v = 0; v < NV; v++) begin
          if (!v_active[v]) begin
            v_note[v] = n;
            v_vel[v] = vel;
            v_active[v] = 1'b1;
            v_gate[v] = 1'b1;
            v_time[v] = '0;
            break;
          end
        end
      end
      MODE_NOTE_OFF: begin
        for (int v = 0; v < NV; v++) begin
          if (v_active[v] && v_gate[v] && v_note[v] == n) begin
            v_time[v] = '0;
            v_gate[v] = 1'b0;
          end
        end
      end
      MODE_TICK: begin
        sample_queue.push_back(mix_tick());
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_event(mode_e m, logic [6:0] n, logic [6:0] vel);
    int unsigned gap;
    gap = $urandom_range(0, 5);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= m;
    in_ch.note_number <= n;
    in_ch.key_velocity <= vel;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_event(m, n, vel);
    events_sent++;
    if (m == MODE_TICK) begin
      ticks_sent++;
    end
  endtask

  // drop the input valid once the sender stops offering
  task automatic idle_input();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    idle_input();
    while (sample_queue.size() != 0) @(posedge clk_i);
    repeat (IDLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    case (idx)
      CFG_ATTACK:  p_attack = value[23:0];
      CFG_DECAY:   p_decay = value[23:0];
      CFG_SUSTAIN: p_sustain = value[16:0];
      CFG_RELEASE: p_release = value[23:0];
      CFG_RATIO:   p_ratio = value[15:0];
      CFG_DEPTH:   p_depth = value;
      CFG_GAIN:    p_gain = value[11:0];
      default: begin
      end
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_regs(logic [31:0] a, logic [31:0] d, logic [31:0] s, logic [31:0] r,
                           logic [31:0] ratio, logic [31:0] depth, logic [31:0] gain);
    drain();
    write_reg(CFG_ATTACK, a);
    write_reg(CFG_DECAY, d);
    write_reg(CFG_SUSTAIN, s);
    write_reg(CFG_RELEASE, r);
    write_reg(CFG_RATIO, ratio);
    write_reg(CFG_DEPTH, depth);
    write_reg(CFG_GAIN, gain);
  endtask

  task automatic ticks(int unsigned count);
    repeat (count) send_event(MODE_TICK, 7'($urandom), 7'($urandom));
  endtask

  // directed: note extremes, voice limit, note-off, unused mode
  task automatic test_directed();
    load_regs(2, 3, 40000, 4, 4096, 32'd9739155, 4095);
    send_event(MODE_NOTE_ON, 7'd0, 7'd127);
    send_event(MODE_NOTE_ON, 7'd127, 7'd127);
    send_event(MODE_NOTE_ON, 7'd69, 7'd0);
    for (int i = 0; i < 6; i++) begin
      send_event(MODE_NOTE_ON, 7'(60 + i), 7'(100 + i));
    end
    send_event(MODE_NONE, 7'd127, 7'd127);
    ticks(6);
    send_event(MODE_NOTE_OFF, 7'd127, 7'd0);
    send_event(MODE_NOTE_OFF, 7'd60, 7'd0);
    send_event(MODE_NOTE_OFF, 7'd99, 7'd0);
    ticks(8);
    send_event(MODE_NOTE_ON, 7'd85, 7'd42);
    ticks(2);
  endtask

  // register extremes: zero durations, oversized sustain, full depth and gain
  task automatic test_reg_extremes();
    load_regs(0, 0, 32'h1FFFF, 0, 16'hFFFF, 32'hFFFFFFFF, 4095);
    for (int i = 0; i < 8; i++) begin
      send_event(MODE_NOTE_ON, 7'($urandom), 7'd127);
    end
    ticks(6);
    for (int n = 0; n < 128; n++) begin
      send_event(MODE_NOTE_OFF, 7'(n), 7'($urandom));
    end
    ticks(4);
    load_regs(24'hFFFFFF, 24'hFFFFFF, 0, 24'hFFFFFF, 0, 0, 0);
    ticks(3);
    load_regs(1, 1, 65536, 24'hFFFFFF, 30720, 9739155, 500);
    send_event(MODE_NOTE_OFF, 7'($urandom), 7'd0);
    ticks(3);
    for (int n = 0; n < 128; n++) begin
      send_event(MODE_NOTE_OFF, 7'(n), 7'd0);
    end
    ticks(3);
  endtask

  // random: well-formed note sequences with random content plus noise
  task automatic test_random(int unsigned count);
    logic [6:0] held [$];
    int unsigned pick;
    logic [6:0] n;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        n = 7'($urandom);
        held.push_back(n);
        send_event(MODE_NOTE_ON, n, 7'($urandom));
      end else if (pick < 32 && held.size() != 0) begin
        n = held[$urandom_range(0, held.size() - 1)];
        send_event(MODE_NOTE_OFF, n, 7'($urandom));
      end else if (pick < 36) begin
        send_event(MODE_NOTE_OFF, 7'($urandom), 7'($urandom));
      end else if (pick < 38) begin
        send_event(MODE_NONE, 7'($urandom), 7'($urandom));
      end else begin
        send_event(MODE_TICK, 7'($urandom), 7'($urandom));
      end
      if (held.size() > 16) begin
        void'(held.pop_front());
      end
    end
  endtask

  task automatic test_backpressure();
    rand_stall = 1'b0;
    hold_off = 2000;
    for (int i = 0; i < 4; i++) begin
      send_event(MODE_NOTE_ON, 7'($urandom), 7'($urandom));
    end
    ticks(6);
    idle_input();
    while (hold_off != 0) @(posedge clk_i);
    rand_stall = 1'b1;
    test_random(100);
    // pause until every sample is back
    drain();
    test_random(100);
  endtask

  // sink side: random stalls, a long hold-off when asked, ordered compare
  initial begin
    int unsigned gap;
    logic signed [15:0] want;
    out_ch.ready = 1'b0;
    gap = 0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        samples_seen++;
        if (sample_queue.size() == 0) begin
          $error("unexpected audio_sample %0d", out_ch.audio_sample);
          errors++;
        end else begin
          want = sample_queue.pop_front();
          if (want !== out_ch.audio_sample) begin
            $error("audio_sample expected %0d actual %0d", want, out_ch.audio_sample);
            errors++;
          end
        end
        gap = rand_stall ? $urandom_range(0, 5) : 0;
      end
      if (hold_off != 0) begin
        hold_off--;
        out_ch.ready <= 1'b0;
      end else if (gap != 0) begin
        gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
          || (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else if (++idle_cycles >= WD_LIMIT) begin
        $display("watchdog expired");
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_NONE;
    in_ch.note_number = '0;
    in_ch.key_velocity = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    errors = 0;
    ticks_sent = 0;
    events_sent = 0;
    samples_seen = 0;
    hold_off = 0;
    rand_stall = 1'b1;
    p_attack = 24'd441;
    p_decay = 24'd35280;
    p_sustain = 17'd6554;
    p_release = 24'd8820;
    p_ratio = 16'd30720;
    p_depth = 32'd9739155;
    p_gain = 12'd500;
    for (int v = 0; v < NV; v++) begin
      v_active[v] = 1'b0;
      v_gate[v] = 1'b0;
      v_note[v] = '0;
      v_vel[v] = '0;
      v_time[v] = '0;
      v_level[v] = '0;
      v_carrier[v] = '0;
      v_mod[v] = '0;
    end
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_random(150);
    test_directed();
    test_reg_extremes();
    load_regs(3, 5, 30000, 6, 12288, 32'd50000000, 2000);
    test_backpressure();
    load_regs(441, 35280, 6554, 8820, 30720, 9739155, 500);
    test_random(400);
    load_regs(20, 40, 20000, 30, 8192, 32'd20000000, 4095);
    test_random(500);
    drain();
    $display("ran %0d events, %0d ticks, %0d samples checked over several register sets",
             events_sent, ticks_sent, samples_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/pfmvs_pkg.sv
rtl/core/pfmvs_if.sv
rtl/core/pfmvs_div.sv
rtl/core/polyphonic_fm_voice_synth_core.sv
tb/sv/tb_pfmvs_if.sv
tb/sv/tb.sv
